[src/qte_pkg.sv]
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants
// Arctangent table, queue depth and flag groups used by the front and back.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int ATAN_LEN    = 32;
    // larger operand magnitude is brought into [2^29, 2^30)
    localparam int NORM_TOP    = 30;
    localparam int CORDIC_W    = 34;
    localparam int ANGLE_ACC_W = 33;

    // pitch classification that travels from the front to the back
    typedef struct packed {
        logic clamped;
        logic s_neg;
    } pitch_flags_t;

    // quadrant fix information carried along the cordic pipeline
    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic zero;
    } quad_t;

    // atan(2^-i), pi = 2^31
    function automatic logic [31:0] atan_tab(input int i);
        logic [31:0] v;
        case (i)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            24:      v = 32'd41;
            25:      v = 32'd20;
            26:      v = 32'd10;
            27:      v = 32'd5;
            28:      v = 32'd3;
            29:      v = 32'd1;
            30:      v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[src/qte_front.sv]
// ----------------------------------------------------------------------------
// qte_front: product terms, pitch classification and pitch cosine
// Stall-all pipeline: products, sums, clamp check, (1-s)(1+s), bitwise sqrt.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_front #(
    parameter int QUAT_FRAC_BITS = 14,
    parameter int TW             = 36
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    en,
    input  wire                    in_valid,
    input  wire  signed [15:0]     quat_w,
    input  wire  signed [15:0]     quat_x,
    input  wire  signed [15:0]     quat_y,
    input  wire  signed [15:0]     quat_z,
    output logic                   out_valid,
    output logic signed [TW-1:0]   out_sr,
    output logic signed [TW-1:0]   out_cr,
    output logic signed [TW-1:0]   out_sy,
    output logic signed [TW-1:0]   out_cy,
    output logic signed [TW-1:0]   out_py,
    output logic signed [TW-1:0]   out_px,
    output qte_pkg::pitch_flags_t  out_flags
);

    localparam int F     = QUAT_FRAC_BITS;
    localparam int R     = (2 * F > 30) ? (2 * F - 30) : 0;
    localparam int OW    = 2 * F - R + 1;
    localparam int K     = OW - 1;
    localparam int NW    = 2 * K;
    localparam int DEPTH = 4 + K;
    localparam int SW    = 4 * TW + OW + 2;
    localparam logic [TW-1:0] ONE   = TW'(1) << (2 * F);
    localparam logic [OW-1:0] O_VAL = OW'(1) << K;

    logic [DEPTH-1:0] v_reg;

    // stage 1: products
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wz_reg;
    logic signed [31:0] xy_reg, zz_reg, wy_reg, zx_reg;
    // stage 2: sums of products
    logic signed [TW-1:0] sr2_reg, cr2_reg, sy2_reg, cy2_reg, sp2_reg;
    // stage 3: clamp check and factors
    logic signed [TW-1:0] sr3_reg, cr3_reg, sy3_reg, cy3_reg;
    logic [OW-1:0]        d3_reg, e3_reg, a3_reg;
    qte_pkg::pitch_flags_t f3_reg;
    // stage 4: radicand
    logic [NW-1:0]        n4_reg;
    logic [SW-1:0]        sd4_reg;

    logic [TW-1:0] sp_mag;
    logic [OW-1:0] a_next;

    always_comb
    begin
        sp_mag = sp2_reg[TW-1] ? TW'(-sp2_reg) : TW'(sp2_reg);
        a_next = OW'(sp_mag >> R);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg  <= quat_w * quat_x;
            yz_reg  <= quat_y * quat_z;
            xx_reg  <= quat_x * quat_x;
            yy_reg  <= quat_y * quat_y;
            wz_reg  <= quat_w * quat_z;
            xy_reg  <= quat_x * quat_y;
            zz_reg  <= quat_z * quat_z;
            wy_reg  <= quat_w * quat_y;
            zx_reg  <= quat_z * quat_x;

            sr2_reg <= (TW'(wx_reg) + TW'(yz_reg)) <<< 1;
            cr2_reg <= signed'(ONE) - ((TW'(xx_reg) + TW'(yy_reg)) <<< 1);
            sp2_reg <= (TW'(wy_reg) - TW'(zx_reg)) <<< 1;
            sy2_reg <= (TW'(wz_reg) + TW'(xy_reg)) <<< 1;
            cy2_reg <= signed'(ONE) - ((TW'(yy_reg) + TW'(zz_reg)) <<< 1);

            sr3_reg <= sr2_reg;
            cr3_reg <= cr2_reg;
            sy3_reg <= sy2_reg;
            cy3_reg <= cy2_reg;
            a3_reg  <= a_next;
            d3_reg  <= O_VAL - a_next;
            e3_reg  <= O_VAL + a_next;
            f3_reg.clamped <= (sp_mag >= ONE);
            // sign of the sine itself, also when the truncated magnitude wraps to zero
            f3_reg.s_neg   <= sp2_reg[TW-1];

            n4_reg  <= NW'(d3_reg * e3_reg);
            sd4_reg <= {sr3_reg, cr3_reg, sy3_reg, cy3_reg, a3_reg, f3_reg};
        end
    end

    // digit-by-digit square root, one result bit per stage
    logic [NW-1:0] rem_s [0:K];
    logic [NW-1:0] res_s [0:K];
    logic [SW-1:0] sd_s  [0:K];

    assign rem_s[0] = n4_reg;
    assign res_s[0] = '0;
    assign sd_s[0]  = sd4_reg;

    for (genvar j = 0; j < K; j++)
    begin : g_sqrt
        localparam logic [NW-1:0] BIT = NW'(1) << (NW - 2 - 2 * j);
        logic [NW-1:0] rem_reg, res_reg, trial;
        logic [SW-1:0] sd_reg;

        assign trial = res_s[j] + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sd_reg <= sd_s[j];
                if (rem_s[j] >= trial)
                begin
                    rem_reg <= rem_s[j] - trial;
                    res_reg <= (res_s[j] >> 1) + BIT;
                end
                else
                begin
                    rem_reg <= rem_s[j];
                    res_reg <= res_s[j] >> 1;
                end
            end
        end

        assign rem_s[j+1] = rem_reg;
        assign res_s[j+1] = res_reg;
        assign sd_s[j+1]  = sd_reg;
    end

    logic [OW-1:0] a_out;
    logic [K-1:0]  c_out;

    assign c_out     = res_s[K][K-1:0];
    assign a_out     = sd_s[K][OW+1:2];
    assign out_flags = qte_pkg::pitch_flags_t'(sd_s[K][1:0]);
    assign out_sr    = signed'(sd_s[K][SW-1 -: TW]);
    assign out_cr    = signed'(sd_s[K][SW-1-TW -: TW]);
    assign out_sy    = signed'(sd_s[K][SW-1-2*TW -: TW]);
    assign out_cy    = signed'(sd_s[K][SW-1-3*TW -: TW]);
    assign out_px    = signed'(TW'(c_out));
    assign out_py    = out_flags.s_neg ? -signed'(TW'(a_out)) : signed'(TW'(a_out));
    assign out_valid = v_reg[DEPTH-1];

endmodule

`default_nettype wire

[src/qte_fifo.sv]
// ----------------------------------------------------------------------------
// qte_fifo: short queue between front and back
// Register-based, one push and one pop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_fifo #(
    parameter int W = 8
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          push,
    input  wire  [W-1:0] push_data,
    input  wire          pop,
    output logic [W-1:0] pop_data,
    output logic         full,
    output logic         empty
);

    localparam int AW = qte_pkg::QUEUE_AW;

    logic [W-1:0]  mem_reg [0:qte_pkg::QUEUE_DEPTH-1];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;

    assign full     = (cnt_reg == (AW+1)'(qte_pkg::QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[src/qte_atan2.sv]
// ----------------------------------------------------------------------------
// qte_atan2: pipelined atan2
// Magnitude, staged normalization, one cordic step per stage, quadrant fix.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_atan2 #(
    parameter int TW           = 36,
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire                         clk,
    input  wire                         en,
    input  wire  signed [TW-1:0]        y,
    input  wire  signed [TW-1:0]        x,
    output logic        [ANGLE_BITS-1:0] angle
);

    localparam int AB  = ANGLE_BITS;
    localparam int ST  = CORDIC_STEPS;
    localparam int CW  = qte_pkg::CORDIC_W;
    localparam int ZW  = qte_pkg::ANGLE_ACC_W;
    localparam int NT  = qte_pkg::NORM_TOP;
    localparam int NS  = 11;
    localparam int QN  = NS + ST + 1;
    localparam int SH  = 32 - AB;
    localparam logic [31:0] RND = (32'd1 << SH) >> 1;

    logic [TW-1:0]  nx [0:NS];
    logic [TW-1:0]  ny [0:NS];
    qte_pkg::quad_t qd [0:QN-1];

    logic [TW-1:0]  ax0_reg, ay0_reg;
    qte_pkg::quad_t qd0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax0_reg       <= x[TW-1] ? TW'(-x) : TW'(x);
            ay0_reg       <= y[TW-1] ? TW'(-y) : TW'(y);
            qd0_reg.x_neg <= x[TW-1];
            qd0_reg.y_neg <= y[TW-1];
            qd0_reg.zero  <= (x == '0) && (y == '0);
        end
    end

    assign nx[0] = ax0_reg;
    assign ny[0] = ay0_reg;
    assign qd[0] = qd0_reg;

    // six right-shift stages then five left-shift stages
    for (genvar s = 0; s < NS; s++)
    begin : g_norm
        localparam bit RIGHT = (s < 6);
        localparam int SA    = RIGHT ? (32 >> s) : (16 >> (s - 6));
        logic [TW-1:0] m, nx_reg, ny_reg;
        logic          hit;

        always_comb
        begin
            m = nx[s] | ny[s];
            if (RIGHT)
            begin
                hit = (m >> (NT - 1 + SA)) != '0;
            end
            else
            begin
                hit = (m >> (NT - SA)) == '0;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!hit)
                begin
                    nx_reg <= nx[s];
                    ny_reg <= ny[s];
                end
                else if (RIGHT)
                begin
                    nx_reg <= nx[s] >> SA;
                    ny_reg <= ny[s] >> SA;
                end
                else
                begin
                    nx_reg <= nx[s] << SA;
                    ny_reg <= ny[s] << SA;
                end
            end
        end

        assign nx[s+1] = nx_reg;
        assign ny[s+1] = ny_reg;
    end

    for (genvar k = 0; k < QN - 1; k++)
    begin : g_quad
        qte_pkg::quad_t q_reg;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg <= qd[k];
            end
        end
        assign qd[k+1] = q_reg;
    end

    logic signed [CW-1:0] cx [0:ST];
    logic signed [CW-1:0] cy [0:ST];
    logic signed [ZW-1:0] cz [0:ST];

    assign cx[0] = signed'(CW'(nx[NS][NT-1:0]));
    assign cy[0] = signed'(CW'(ny[NS][NT-1:0]));
    assign cz[0] = '0;

    for (genvar i = 0; i < ST; i++)
    begin : g_cordic
        localparam logic signed [ZW-1:0] ATN = signed'(ZW'(qte_pkg::atan_tab(i)));
        logic signed [CW-1:0] cx_reg, cy_reg;
        logic signed [ZW-1:0] cz_reg;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!cy[i][CW-1])
                begin
                    cx_reg <= cx[i] + (cy[i] >>> i);
                    cy_reg <= cy[i] - (cx[i] >>> i);
                    cz_reg <= cz[i] + ATN;
                end
                else
                begin
                    cx_reg <= cx[i] - (cy[i] >>> i);
                    cy_reg <= cy[i] + (cx[i] >>> i);
                    cz_reg <= cz[i] - ATN;
                end
            end
        end

        assign cx[i+1] = cx_reg;
        assign cy[i+1] = cy_reg;
        assign cz[i+1] = cz_reg;
    end

    // clamp to [0, pi/2], round, fold into the right quadrant
    logic [31:0]          zc, zr;
    logic signed [AB+1:0] qm, qs;
    logic [AB-1:0]        angle_reg;
    qte_pkg::quad_t       qf;

    always_comb
    begin
        qf = qd[QN-1];
        if (cz[ST][ZW-1])
        begin
            zc = '0;
        end
        else if (cz[ST] > signed'(ZW'(1) << NT))
        begin
            zc = 32'd1 << NT;
        end
        else
        begin
            zc = 32'(cz[ST]);
        end
        zr = (zc + RND) >> SH;
        qm = qf.x_neg ? (signed'((AB+2)'(1) << (AB - 1)) - signed'((AB+2)'(zr)))
                      : signed'((AB+2)'(zr));
        qs = qf.y_neg ? -qm : qm;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= qf.zero ? '0 : qs[AB-1:0];
        end
    end

    assign angle = angle_reg;

endmodule

`default_nettype wire

[src/qte_back.sv]
// ----------------------------------------------------------------------------
// qte_back: three atan2 pipelines and result assembly
// Stall-all pipeline whose last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_back #(
    parameter int TW           = 36,
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire  signed [TW-1:0]   sr,
    input  wire  signed [TW-1:0]   cr,
    input  wire  signed [TW-1:0]   sy,
    input  wire  signed [TW-1:0]   cy,
    input  wire  signed [TW-1:0]   py,
    input  wire  signed [TW-1:0]   px,
    input  wire qte_pkg::pitch_flags_t flags,
    output logic                   out_valid,
    input  wire                    out_ready,
    output logic [15:0]            roll_angle,
    output logic [15:0]            pitch_angle,
    output logic [15:0]            yaw_angle,
    output logic                   pitch_clamped
);

    localparam int AB  = ANGLE_BITS;
    localparam int LAT = 13 + CORDIC_STEPS;
    localparam logic signed [AB-1:0] QTR = signed'(AB'(1) << (AB - 2));

    logic                  en;
    logic [LAT-1:0]        v_reg;
    qte_pkg::pitch_flags_t pf_reg [0:LAT-1];
    logic [AB-1:0]         roll_a, pitch_a, yaw_a;
    logic signed [AB-1:0]  pitch_sel;

    assign en        = !v_reg[LAT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = v_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pf_reg[0] <= flags;
            for (int k = 1; k < LAT; k++)
            begin
                pf_reg[k] <= pf_reg[k-1];
            end
        end
    end

    qte_atan2 #(.TW(TW), .ANGLE_BITS(AB), .CORDIC_STEPS(CORDIC_STEPS)) u_roll (
        .clk   (clk),
        .en    (en),
        .y     (sr),
        .x     (cr),
        .angle (roll_a)
    );

    qte_atan2 #(.TW(TW), .ANGLE_BITS(AB), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
        .clk   (clk),
        .en    (en),
        .y     (py),
        .x     (px),
        .angle (pitch_a)
    );

    qte_atan2 #(.TW(TW), .ANGLE_BITS(AB), .CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
        .clk   (clk),
        .en    (en),
        .y     (sy),
        .x     (cy),
        .angle (yaw_a)
    );

    always_comb
    begin
        if (pf_reg[LAT-1].clamped)
        begin
            pitch_sel = pf_reg[LAT-1].s_neg ? -QTR : QTR;
        end
        else
        begin
            pitch_sel = signed'(pitch_a);
        end
    end

    assign roll_angle    = 16'(signed'(roll_a));
    assign pitch_angle   = 16'(pitch_sel);
    assign yaw_angle     = 16'(signed'(yaw_a));
    assign pitch_clamped = pf_reg[LAT-1].clamped;

endmodule

`default_nettype wire

[src/quaternion_to_euler_angles.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: quaternion to z-y-x euler angle converter
// Fixed-point sum-of-products terms, sqrt for the pitch cosine, pipelined cordic.
// ----------------------------------------------------------------------------
// stages: 4 + min(2F,30) front stages (F = QUAT_FRAC_BITS), then the queue,
//   then 13 + CORDIC_STEPS back stages
// throughput: one item per cycle when the output is not stalled, set by the fully pipelined sqrt and cordic
// reset: rst_n clears all valid bits and the queue; data registers are not reset
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_angles #(
    parameter int QUAT_FRAC_BITS = 14,
    parameter int ANGLE_BITS     = 16,
    parameter int CORDIC_STEPS   = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    // input items
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    // result items
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,   // roll_angle, pitch_angle, yaw_angle
    output logic        m_tuser    // pitch_clamped
);

    // term width: holds 1.0 in Q(2F) and doubled 16x16 product sums
    localparam int TW = (2 * QUAT_FRAC_BITS + 3 > 36) ? (2 * QUAT_FRAC_BITS + 3) : 36;
    localparam int QW = 6 * TW + 2;

    // front side
    logic                  f_en, f_valid;
    logic signed [TW-1:0]  f_sr, f_cr, f_sy, f_cy, f_py, f_px;
    qte_pkg::pitch_flags_t f_flags;

    // queue
    logic          q_push, q_pop, q_full, q_empty;
    logic [QW-1:0] q_in, q_out;

    // back side
    logic          b_ready;
    logic [15:0]   roll_angle, pitch_angle, yaw_angle;
    logic          pitch_clamped;

    // front stalls only when its last stage holds an item the queue cannot take
    assign f_en     = !f_valid || !q_full;
    assign s_tready = f_en;
    assign q_push   = f_valid && !q_full;

    qte_front #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS), .TW(TW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (f_en),
        .in_valid  (s_tvalid),
        .quat_w    (signed'(s_tdata[15:0])),
        .quat_x    (signed'(s_tdata[31:16])),
        .quat_y    (signed'(s_tdata[47:32])),
        .quat_z    (signed'(s_tdata[63:48])),
        .out_valid (f_valid),
        .out_sr    (f_sr),
        .out_cr    (f_cr),
        .out_sy    (f_sy),
        .out_cy    (f_cy),
        .out_py    (f_py),
        .out_px    (f_px),
        .out_flags (f_flags)
    );

    assign q_in = {f_sr, f_cr, f_sy, f_cy, f_py, f_px, f_flags};

    qte_fifo #(.W(QW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign q_pop = b_ready && !q_empty;

    qte_back #(.TW(TW), .ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (!q_empty),
        .in_ready      (b_ready),
        .sr            (signed'(q_out[QW-1 -: TW])),
        .cr            (signed'(q_out[QW-1-TW -: TW])),
        .sy            (signed'(q_out[QW-1-2*TW -: TW])),
        .cy            (signed'(q_out[QW-1-3*TW -: TW])),
        .py            (signed'(q_out[QW-1-4*TW -: TW])),
        .px            (signed'(q_out[QW-1-5*TW -: TW])),
        .flags         (qte_pkg::pitch_flags_t'(q_out[1:0])),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .roll_angle    (roll_angle),
        .pitch_angle   (pitch_angle),
        .yaw_angle     (yaw_angle),
        .pitch_clamped (pitch_clamped)
    );

    assign m_tdata = {yaw_angle, pitch_angle, roll_angle};
    assign m_tuser = pitch_clamped;

    // saturated pitch in the output field
    localparam logic signed [ANGLE_BITS-1:0] QTR_A = signed'(ANGLE_BITS'(1) << (ANGLE_BITS - 2));
    localparam logic [15:0] QTR16  = 16'(QTR_A);
    localparam logic [15:0] NQTR16 = 16'(-QTR_A);

    // a clamped result always carries plus or minus a quarter turn
    a_clamp_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[31:16] == QTR16 || m_tdata[31:16] == NQTR16))
        else $error("clamped pitch is not a quarter turn");

    // back pipeline moves whenever no result is waiting
    a_back_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> b_ready)
        else $error("back stalled with empty output");

    // a full queue alone does not stall the front
    a_front_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (q_full && !f_valid) |-> s_tready)
        else $error("front stalled without a pending item");

endmodule

`default_nettype wire

[test/quaternion_to_euler_angles_checker.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_checker: result predictor and comparator
// Watches both stream channels, computes the expected euler angles for each
// accepted quaternion and compares them in order with the delivered results.
// ----------------------------------------------------------------------------

module quaternion_to_euler_angles_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [63:0] s_tdata,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [47:0] m_tdata,
    input  wire         m_tuser,
    output int          fail_count,
    output int          pending
);

    localparam int FRAC  = 14;
    localparam int ABITS = 16;
    localparam int STEPS = 16;

    typedef struct {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic        clamped;
    } euler_t;

    euler_t angle_queue[$];
    int     mismatches = 0;

    assign fail_count = mismatches;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint wrap_ang(longint v);
        logic [ABITS-1:0] u;
        u = v[ABITS-1:0];
        return longint'($signed(u));
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // vectoring cordic on the first quadrant, then quadrant fix
    function automatic longint cordic_atan2(longint y, longint x);
        longint ax, ay, cx, cy, acc, nx;
        int sh;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        sh = 32 - ABITS;
        if (ax == 0 && ay == 0)
            return 0;
        while (ax >= (64'sd1 <<< 30) || ay >= (64'sd1 <<< 30))
        begin
            ax >>= 1;
            ay >>= 1;
        end
        while (ax < (64'sd1 <<< 29) && ay < (64'sd1 <<< 29))
        begin
            ax <<= 1;
            ay <<= 1;
        end
        cx = ax;
        cy = ay;
        acc = 0;
        for (int i = 0; i < STEPS && i < 32; i++)
        begin
            if (cy >= 0)
            begin
                nx = cx + floor_shift(cy, i);
                cy = cy - floor_shift(cx, i);
                acc += longint'(qte_pkg::atan_tab(i));
            end
            else
            begin
                nx = cx - floor_shift(cy, i);
                cy = cy + floor_shift(cx, i);
                acc -= longint'(qte_pkg::atan_tab(i));
            end
            cx = nx;
        end
        if (acc < 0) acc = 0;
        if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
        if (sh > 0) acc = (acc + (64'sd1 <<< (sh - 1))) >>> sh;
        if (x < 0) acc = (64'sd1 <<< (ABITS - 1)) - acc;
        if (y < 0) acc = -acc;
        return wrap_ang(acc);
    endfunction

    function automatic euler_t predict_euler(logic [63:0] q);
        longint w, x, y, z, one, sr, cr, sp, sy, cyw, mag, o, a, c;
        int r;
        euler_t e;
        w = longint'($signed(q[15:0]));
        x = longint'($signed(q[31:16]));
        y = longint'($signed(q[47:32]));
        z = longint'($signed(q[63:48]));
        one = 64'sd1 <<< (2 * FRAC);
        sr  = 2 * (w * x + y * z);
        cr  = one - 2 * (x * x + y * y);
        sp  = 2 * (w * y - z * x);
        sy  = 2 * (w * z + x * y);
        cyw = one - 2 * (y * y + z * z);
        e.roll = 16'(cordic_atan2(sr, cr));
        e.yaw  = 16'(cordic_atan2(sy, cyw));
        mag = sp < 0 ? -sp : sp;
        if (mag >= one)
        begin
            // pitch saturates at a quarter turn with the sign of the sine
            e.clamped = 1'b1;
            e.pitch = 16'(wrap_ang(sp < 0 ? -(64'sd1 <<< (ABITS - 2))
                                          : (64'sd1 <<< (ABITS - 2))));
        end
        else
        begin
            r = (2 * FRAC > 30) ? 2 * FRAC - 30 : 0;
            o = one >>> r;
            a = mag >>> r;
            c = int_sqrt((o - a) * (o + a));
            e.clamped = 1'b0;
            e.pitch = 16'(cordic_atan2(sp < 0 ? -a : a, c));
        end
        return e;
    endfunction

    initial pending = 0;

    always @(posedge clk)
    begin
        euler_t want;
        euler_t got;
        if (rst_n && s_tvalid && s_tready)
            angle_queue.push_back(predict_euler(s_tdata));
        if (rst_n && m_tvalid && m_tready)
        begin
            got.roll    = m_tdata[15:0];
            got.pitch   = m_tdata[31:16];
            got.yaw     = m_tdata[47:32];
            got.clamped = m_tuser;
            if (angle_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h %b", m_tdata, m_tuser);
            end
            else
            begin
                want = angle_queue.pop_front();
                if (got.roll !== want.roll || got.pitch !== want.pitch
                    || got.yaw !== want.yaw || got.clamped !== want.clamped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp r=%0d p=%0d y=%0d c=%b got r=%0d p=%0d y=%0d c=%b",
                                 $signed(want.roll), $signed(want.pitch), $signed(want.yaw),
                                 want.clamped, $signed(got.roll), $signed(got.pitch),
                                 $signed(got.yaw), got.clamped);
                end
            end
        end
        pending = angle_queue.size();
    end

endmodule

[test/tb_quaternion_to_euler_angles.sv]
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles: testbench top for the euler converter
// Drives directed and random quaternions with random bursts of idling on both
// sides, including a long output stall and a full drain; the checker compares.
// ----------------------------------------------------------------------------

module tb_quaternion_to_euler_angles;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    int          fail_count;
    int          pending;

    // set when random idling stops for the final stretch
    logic        calm = 1'b0;
    // set while the receiver holds off for a long stretch
    logic        hold_off = 1'b0;
    logic        sender_done = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    quaternion_to_euler_angles dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    quaternion_to_euler_angles_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // random component, mostly in range, sometimes anywhere in 16 bits
    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 1) ? 16384 : -16384);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // roughly unit quaternion, so the angles cover the whole circle
    function automatic logic [63:0] rand_unit();
        real a, b, c, d, n;
        a = $signed($urandom_range(0, 2000)) - 1000;
        b = $signed($urandom_range(0, 2000)) - 1000;
        c = $signed($urandom_range(0, 2000)) - 1000;
        d = $signed($urandom_range(0, 2000)) - 1000;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
            return {16'd0, 16'd0, 16'd0, 16'sd16384};
        return {16'($rtoi(d / n * 16384.0)), 16'($rtoi(c / n * 16384.0)),
                16'($rtoi(b / n * 16384.0)), 16'($rtoi(a / n * 16384.0))};
    endfunction

    // offer one item, with an optional idle burst before it
    task automatic send_quat(input logic [63:0] q);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= q;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // receiver: random stall bursts, one long hold-off, none at the end
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 13);
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [15:0] edge_vals [6];
        edge_vals = '{16'sd16384, -16'sd16384, 16'd0, 16'h7fff, 16'h8000, 16'hffff};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, roll/pitch/yaw quarter turns, gimbal lock both signs,
        // all-zero (all sine terms zero), angle exactly pi, field extremes
        send_quat({16'd0, 16'd0, 16'd0, 16'sd16384});
        send_quat({16'd0, 16'd0, 16'd11585, 16'd11585});
        send_quat({16'd0, 16'd11585, 16'd0, 16'd11585});
        send_quat({16'd0, -16'sd11585, 16'd0, 16'd11585});
        send_quat({16'd11585, 16'd0, 16'd0, 16'd11585});
        send_quat({16'd0, 16'd0, 16'd0, 16'd0});
        send_quat({16'd0, 16'd0, 16'sd16384, 16'd0});
        send_quat({16'sd16384, 16'd0, 16'd0, 16'd0});
        send_quat({16'd0, 16'sd16384, 16'd0, 16'd0});
        send_quat({16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192});
        send_quat({-16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192});
        for (int i = 0; i < 6; i++)
            send_quat({edge_vals[(i + 3) % 6], edge_vals[(i + 2) % 6],
                       edge_vals[(i + 1) % 6], edge_vals[i]});
        send_quat({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
        send_quat({16'h8000, 16'h8000, 16'h8000, 16'h8000});

        for (int n = 0; n < 1900; n++)
        begin
            if (n == 600)
            begin
                // long output stall while the input keeps offering
                hold_off = 1'b1;
            end
            if (n == 1000)
            begin
                // pause until everything has drained
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            if (n == 1700)
                calm = 1'b1;
            if ($urandom_range(0, 2) == 0)
                send_quat({rand_comp(), rand_comp(), rand_comp(), rand_comp()});
            else
                send_quat(rand_unit());
        end
        s_tvalid <= 1'b0;
        sender_done = 1'b1;
    end

    initial
    begin
        wait (sender_done);
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
src/qte_pkg.sv
src/qte_front.sv
src/qte_fifo.sv
src/qte_atan2.sv
src/qte_back.sv
src/quaternion_to_euler_angles.sv
test/quaternion_to_euler_angles_checker.sv
test/tb_quaternion_to_euler_angles.sv
